// ===== sv/integer_to_padded_ascii_unit_macros.svh =====
// Assertion macros shared by the integer to padded ASCII unit.
`ifndef INTEGER_TO_PADDED_ASCII_UNIT_MACROS_SVH
`define INTEGER_TO_PADDED_ASCII_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ITPA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("itpa assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ITPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("itpa assertion failed");

`endif

// ===== sv/itpa_pkg.sv =====
// Package: shared types and constants of the integer to padded ASCII unit.
package itpa_pkg;

	localparam int MAX_DIGITS_DEF = 20;
	localparam int VALUE_W        = 64;
	localparam int CNT_W          = 5;
	localparam int RADIX_W        = 5;
	localparam int CHAR_W         = 8;
	localparam int DIGIT_W        = 4;
	localparam int IN_DATA_W      = 88;

	// Radix limits
	localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

	// Divider: bits of the dividend handled per cycle
	localparam int CHUNK_BITS = 8;
	localparam int CHUNKS     = VALUE_W / CHUNK_BITS;
	localparam int CHUNK_CW   = $clog2(CHUNKS);

	// Job queue geometry
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	// Characters
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_ALPHA = 8'h37;
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

	// One classified job, passed from front to back
	typedef struct packed {
		logic [VALUE_W-1:0] mag;
		logic [CNT_W-1:0]   cnt;
		logic [RADIX_W-1:0] radix;
		logic               neg;
		logic [CHAR_W-1:0]  pad;
	} itpa_job_t;

endpackage

// ===== sv/itpa_front.sv =====
// Front end: accepts input items, clamps their fields and resolves the sign.
module itpa_front #(
	parameter int MAX_DIGITS = itpa_pkg::MAX_DIGITS_DEF
) (
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [63:0] value, [68:64] digit_count, [73:69] radix, [81:74] pad_char, rest zero
	input  logic [itpa_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// [0] signed_mode
	input  logic                             s_axis_tuser,
	input  logic                             q_full,
	output logic                             q_push,
	output itpa_pkg::itpa_job_t              q_job
);

	logic [itpa_pkg::VALUE_W-1:0] value;
	logic [itpa_pkg::CNT_W-1:0]   digit_count;
	logic [itpa_pkg::RADIX_W-1:0] radix;
	logic [itpa_pkg::CHAR_W-1:0]  pad_char;
	logic                         neg;

	assign value       = s_axis_tdata[63:0];
	assign digit_count = s_axis_tdata[68:64];
	assign radix       = s_axis_tdata[73:69];
	assign pad_char    = s_axis_tdata[81:74];

	// Accept while the queue has room
	assign s_axis_tready = !q_full;
	assign q_push        = s_axis_tvalid && !q_full;

	// Classify: clamp count and radix, negate negative signed values
	assign neg = s_axis_tuser && value[itpa_pkg::VALUE_W-1];

	always_comb begin
		q_job.pad = pad_char;
		q_job.neg = neg;
		q_job.mag = neg ? (~value + 64'd1) : value;
		if (digit_count == '0) begin
			q_job.cnt = itpa_pkg::CNT_W'(1);
		end else if (digit_count > itpa_pkg::CNT_W'(MAX_DIGITS)) begin
			q_job.cnt = itpa_pkg::CNT_W'(MAX_DIGITS);
		end else begin
			q_job.cnt = digit_count;
		end
		if (radix < itpa_pkg::RADIX_MIN) begin
			q_job.radix = itpa_pkg::RADIX_MIN;
		end else if (radix > itpa_pkg::RADIX_MAX) begin
			q_job.radix = itpa_pkg::RADIX_MAX;
		end else begin
			q_job.radix = radix;
		end
	end

endmodule

// ===== sv/itpa_queue.sv =====
// Two-entry job queue between front and back end.
module itpa_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  itpa_pkg::itpa_job_t push_job,
	input  logic                pop,
	output itpa_pkg::itpa_job_t pop_job,
	output logic                full,
	output logic                empty
);

	itpa_pkg::itpa_job_t                  mem_q [itpa_pkg::Q_DEPTH];
	logic [itpa_pkg::Q_PTR_W-1:0]         wr_ptr_q;
	logic [itpa_pkg::Q_PTR_W-1:0]         rd_ptr_q;
	logic [itpa_pkg::Q_CNT_W-1:0]         count_q;
	logic                                 do_push;
	logic                                 do_pop;

	assign full    = count_q == itpa_pkg::Q_CNT_W'(itpa_pkg::Q_DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_job = mem_q[rd_ptr_q];

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store job
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_job;
	end

endmodule

// ===== sv/itpa_back.sv =====
// Back end: iterative radix conversion and character emission.
`include "integer_to_padded_ascii_unit_macros.svh"
module itpa_back #(
	parameter int MAX_DIGITS = itpa_pkg::MAX_DIGITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  itpa_pkg::itpa_job_t           q_job,
	output logic                          q_pop,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [7:0] char_out
	output logic [itpa_pkg::CHAR_W-1:0]   m_axis_tdata,
	output logic                          m_axis_tlast
);

	localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t                               state_q;
	logic [itpa_pkg::VALUE_W-1:0]         n_q;
	logic [itpa_pkg::DIGIT_W-1:0]         rem_q;
	logic [itpa_pkg::RADIX_W-1:0]         r_q;
	logic [itpa_pkg::CNT_W-1:0]           cnt_q;
	logic [itpa_pkg::CNT_W-1:0]           dcnt_q;
	logic [itpa_pkg::CNT_W-1:0]           pos_q;
	logic [itpa_pkg::CHUNK_CW-1:0]        chunk_q;
	logic [itpa_pkg::CHAR_W-1:0]          pad_q;
	logic                                 minus_q;
	logic                                 started_q;
	logic [itpa_pkg::DIGIT_W-1:0]         dig_q [MAX_DIGITS];
	logic                                 out_valid_q;
	logic [itpa_pkg::CHAR_W-1:0]          out_char_q;
	logic                                 out_last_q;

	logic [itpa_pkg::DIGIT_W-1:0]         rem_nx;
	logic [itpa_pkg::CHUNK_BITS-1:0]      qbits;
	logic [itpa_pkg::RADIX_W-1:0]         trial;
	logic                                 out_free;
	logic [itpa_pkg::DIGIT_W-1:0]         cur_dig;
	logic                                 is_lead;
	logic                                 skip;
	logic                                 emit;
	logic [itpa_pkg::CHAR_W-1:0]          emit_char;
	logic                                 emit_last;
	logic                                 last_chunk;
	logic                                 last_digit;

	// Divide one chunk of the dividend by the radix, MSB first
	always_comb begin
		rem_nx = rem_q;
		qbits  = '0;
		trial  = '0;
		for (int i = 0; i < itpa_pkg::CHUNK_BITS; i++) begin
			trial = {rem_nx, n_q[itpa_pkg::VALUE_W-1-i]};
			if (trial >= r_q) begin
				rem_nx = itpa_pkg::DIGIT_W'(trial - r_q);
				qbits[itpa_pkg::CHUNK_BITS-1-i] = 1'b1;
			end else begin
				rem_nx = trial[itpa_pkg::DIGIT_W-1:0];
			end
		end
	end

	assign last_chunk = chunk_q == itpa_pkg::CHUNK_CW'(itpa_pkg::CHUNKS - 1);
	assign last_digit = dcnt_q == (cnt_q - 1'b1);

	// Pick the next character of the run
	assign out_free = !out_valid_q || m_axis_tready;
	assign cur_dig  = dig_q[pos_q[IDX_W-1:0]];
	assign is_lead  = (cur_dig == '0) && !started_q && (pos_q != '0) && !minus_q;
	assign skip     = (state_q == ST_EMIT) && is_lead && (pad_q == itpa_pkg::CH_NUL);
	assign emit     = (state_q == ST_EMIT) && !skip && out_free;

	always_comb begin
		emit_last = 1'b0;
		if (minus_q) begin
			emit_char = itpa_pkg::CH_MINUS;
		end else if (is_lead) begin
			emit_char = pad_q;
		end else begin
			emit_last = pos_q == '0;
			if (cur_dig < 4'd10) begin
				emit_char = itpa_pkg::CH_ZERO + itpa_pkg::CHAR_W'(cur_dig);
			end else begin
				emit_char = itpa_pkg::CH_ALPHA + itpa_pkg::CHAR_W'(cur_dig);
			end
		end
	end

	assign q_pop = (state_q == ST_IDLE) && !q_empty;

	// Sequence: load job, divide digit by digit, emit characters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			chunk_q     <= '0;
			dcnt_q      <= '0;
			pos_q       <= '0;
			minus_q     <= 1'b0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q   <= ST_DIV;
						chunk_q   <= '0;
						dcnt_q    <= '0;
						minus_q   <= q_job.neg;
						started_q <= 1'b0;
					end
				end
				ST_DIV: begin
					chunk_q <= chunk_q + 1'b1;
					if (last_chunk) begin
						if (last_digit) begin
							state_q <= ST_EMIT;
							pos_q   <= cnt_q - 1'b1;
						end else begin
							dcnt_q <= dcnt_q + 1'b1;
						end
					end
				end
				ST_EMIT: begin
					if (emit || skip) begin
						if (minus_q) begin
							minus_q <= 1'b0;
						end else begin
							if (!is_lead) started_q <= 1'b1;
							if (pos_q == '0) begin
								state_q <= ST_IDLE;
							end else begin
								pos_q <= pos_q - 1'b1;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold job payload, dividend, digits and output character
	always_ff @(posedge clk) begin
		if (q_pop) begin
			n_q   <= q_job.mag;
			r_q   <= q_job.radix;
			cnt_q <= q_job.cnt;
			pad_q <= q_job.pad;
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			n_q <= {n_q[itpa_pkg::VALUE_W-itpa_pkg::CHUNK_BITS-1:0], qbits};
			if (last_chunk) begin
				rem_q                    <= '0;
				dig_q[dcnt_q[IDX_W-1:0]] <= rem_nx;
			end else begin
				rem_q <= rem_nx;
			end
		end
		if (emit) begin
			out_char_q <= emit_char;
			out_last_q <= emit_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_char_q;
	assign m_axis_tlast  = out_last_q;

	`ITPA_ASSERT_IMPL(a_rem_below_radix, clk, arst_n, state_q == ST_DIV, rem_q < r_q)
	`ITPA_ASSERT_IMPL(a_last_not_minus, clk, arst_n, out_valid_q && out_last_q, out_char_q != itpa_pkg::CH_MINUS)
	`ITPA_ASSERT_IMPL(a_pos_in_range, clk, arst_n, state_q == ST_EMIT, pos_q < itpa_pkg::CNT_W'(MAX_DIGITS))
	`ITPA_ASSERT_NEXT(a_done_marks_last, clk, arst_n, (state_q == ST_EMIT) && (emit || skip) && !minus_q && (pos_q == '0), out_valid_q && out_last_q)

endmodule

// ===== sv/integer_to_padded_ascii_unit.sv =====
// Top level of the integer to padded ASCII unit.
//
// Usage: each input item on the s_axis channel carries a 64-bit value, a
// digit count, a radix, a pad character (tdata) and the signed flag (tuser).
// The unit answers with a run of ASCII characters on m_axis, one per item,
// with tlast set on the final digit of the run. A negative signed value
// starts with '-'. Leading zeros become the pad character, or are dropped
// when the pad character is zero.
// Timing: the back end divides by the radix eight dividend bits per cycle,
// one digit at a time over all dividend chunks, then emits the characters
// of the run, stepping also over each dropped zero. A two-entry job queue
// lets the input side accept up to two further items during a conversion.
// Reset (arst_n low) empties the queue, drops any run in progress and
// clears m_axis_tvalid. When the receiver holds tready low, the current
// character stays in the output register and conversion of the next
// character waits; the queue keeps taking items until it is full.
module integer_to_padded_ascii_unit #(
	parameter int MAX_DIGITS = itpa_pkg::MAX_DIGITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [63:0] value, [68:64] digit_count, [73:69] radix, [81:74] pad_char, rest zero
	input  logic [itpa_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// [0] signed_mode
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [7:0] char_out
	output logic [itpa_pkg::CHAR_W-1:0]      m_axis_tdata,
	// last_char
	output logic                             m_axis_tlast
);

	itpa_pkg::itpa_job_t push_job;
	itpa_pkg::itpa_job_t pop_job;
	logic                push;
	logic                pop;
	logic                full;
	logic                empty;

	itpa_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (full),
		.q_push        (push),
		.q_job         (push_job)
	);

	itpa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.full     (full),
		.empty    (empty)
	);

	itpa_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (empty),
		.q_job         (pop_job),
		.q_pop         (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ===== tb/ascii_run_checker.sv =====
// Checker for the integer to padded ASCII unit: predicts each character run and compares it.
module ascii_run_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [itpa_pkg::IN_DATA_W-1:0] in_data,
	input  logic                           in_signed,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [itpa_pkg::CHAR_W-1:0]    out_char,
	input  logic                           out_last,
	output int                             failures,
	output int                             pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import itpa_pkg::*;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} ascii_char_t;

	ascii_char_t chars_due[$];
	int          mismatch_total = 0;

	// Queue one character of the run expected for the current number
	task automatic push_char(input logic [CHAR_W-1:0] code, input logic last);
		ascii_char_t c;
		c.code = code;
		c.last = last;
		chars_due.push_back(c);
	endtask

	// Format one number the way the unit should: sign, truncated digits, padding
	task automatic format_number(input logic [IN_DATA_W-1:0] data, input logic sgn);
		logic [VALUE_W-1:0] mag;
		int                 digits;
		logic [RADIX_W-1:0] base;
		logic [CHAR_W-1:0]  pad;
		logic [DIGIT_W-1:0] digit_val [MAX_DIGITS_DEF];
		logic               leading;
		int                 pos;
		mag    = data[63:0];
		digits = int'(data[68:64]);
		base   = data[73:69];
		pad    = data[81:74];
		// Clamp the digit count and the radix into their legal ranges
		if (digits < 1)
			digits = 1;
		if (digits > MAX_DIGITS_DEF)
			digits = MAX_DIGITS_DEF;
		if (base < RADIX_MIN)
			base = RADIX_MIN;
		if (base > RADIX_MAX)
			base = RADIX_MAX;
		// Negative in signed mode: emit the sign, then work on the magnitude
		if (sgn && mag[VALUE_W-1]) begin
			push_char(CH_MINUS, 1'b0);
			mag = -mag;
		end
		// Split into digits, least significant first; excess digits fall away
		for (pos = 0; pos < digits; pos++) begin
			digit_val[pos] = DIGIT_W'(mag % VALUE_W'(base));
			mag = mag / VALUE_W'(base);
		end
		// Emit most significant first, padding or dropping leading zeros
		leading = 1'b1;
		for (pos = digits - 1; pos >= 0; pos--) begin
			if (digit_val[pos] == '0 && leading && pos != 0) begin
				if (pad != CH_NUL)
					push_char(pad, 1'b0);
			end else begin
				leading = 1'b0;
				if (digit_val[pos] < 10)
					push_char(CH_ZERO + CHAR_W'(digit_val[pos]), pos == 0);
				else
					push_char(CH_ALPHA + CHAR_W'(digit_val[pos]), pos == 0);
			end
		end
	endtask

	// Predict on every accepted number, compare every accepted character
	always @(posedge clk) begin
		ascii_char_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				format_number(in_data, in_signed);
			if (out_valid && out_ready) begin
				if (chars_due.size() == 0) begin
					$error("char_out %h arrived with no character expected", out_char);
					mismatch_total++;
				end else begin
					want = chars_due.pop_front();
					if (want.code !== out_char) begin
						$error("char_out mismatch: expected %h, actual %h", want.code, out_char);
						mismatch_total++;
					end
					if (want.last !== out_last) begin
						$error("last_char mismatch: expected %b, actual %b", want.last, out_last);
						mismatch_total++;
					end
				end
			end
		end
		failures <= mismatch_total;
		pending  <= chars_due.size();
	end

endmodule

// ===== tb/testbench.sv =====
// Testbench top: clock, reset, number stimulus, output stalls and the verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import itpa_pkg::*;

	localparam int RANDOM_ITEMS = 207;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 200;
	localparam int IDLE_PCT     = 31;
	localparam int HOLD_START   = 5000;
	localparam int HOLD_CYCLES  = 300;
	localparam int CALM_RX_LO   = 12000;
	localparam int CALM_RX_HI   = 16000;
	localparam int CALM_TX_LO   = 120;
	localparam int CALM_TX_HI   = 160;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata;
	logic                 s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [CHAR_W-1:0]    m_axis_tdata;
	logic                 m_axis_tlast;

	int fail_count;
	int pending;
	int numbers_sent = 0;
	int quiet_cycles = 0;
	int rx_cycle = 0;
	int n;

	integer_to_padded_ascii_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	ascii_run_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.in_signed (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.failures  (fail_count),
		.pending   (pending)
	);

	always #5 clk = ~clk;

	// Offer one number, idling first at random outside the calm stretch
	task automatic send_number(input logic [VALUE_W-1:0] value, input logic [CNT_W-1:0] cnt,
			input logic [RADIX_W-1:0] radix, input logic sgn, input logic [CHAR_W-1:0] pad);
		while (!(numbers_sent >= CALM_TX_LO && numbers_sent < CALM_TX_HI) &&
				$urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= IN_DATA_W'({$urandom, $urandom, $urandom});
			s_axis_tuser  <= 1'($urandom);
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'd0, pad, radix, cnt, value};
		s_axis_tuser  <= sgn;
		do
			@(posedge clk);
		while (!s_axis_tready);
		numbers_sent++;
	endtask

	// Draw one number: mostly plausible values and formats, some out-of-range fields
	task automatic send_random_number();
		logic [VALUE_W-1:0] value;
		logic [CNT_W-1:0]   cnt;
		logic [RADIX_W-1:0] radix;
		logic [CHAR_W-1:0]  pad;
		int                 pick;
		pick = $urandom_range(99);
		if (pick < 40)
			value = {$urandom, $urandom};
		else if (pick < 60)
			value = {$urandom, $urandom} >> $urandom_range(63);
		else if (pick < 75)
			value = VALUE_W'($urandom_range(999));
		else if (pick < 88)
			value = -VALUE_W'($urandom_range(999) + 1);
		else begin
			case ($urandom_range(3))
				0: value = '0;
				1: value = '1;
				2: value = 64'h8000_0000_0000_0000;
				default: value = 64'h7FFF_FFFF_FFFF_FFFF;
			endcase
		end
		if ($urandom_range(9) == 0)
			cnt = CNT_W'($urandom_range(31));
		else
			cnt = CNT_W'($urandom_range(20, 1));
		pick = $urandom_range(99);
		if (pick < 10)
			radix = RADIX_W'($urandom_range(31));
		else if (pick < 60) begin
			case ($urandom_range(3))
				0: radix = 5'd2;
				1: radix = 5'd8;
				2: radix = 5'd10;
				default: radix = 5'd16;
			endcase
		end else
			radix = RADIX_W'($urandom_range(16, 2));
		pick = $urandom_range(99);
		if (pick < 35)
			pad = CH_NUL;
		else if (pick < 60)
			pad = CH_ZERO;
		else if (pick < 80)
			pad = CH_SPACE;
		else
			pad = CHAR_W'($urandom);
		send_number(value, cnt, radix, 1'($urandom), pad);
	endtask

	// Reset, directed numbers, random numbers, then drain and report
	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero with every padding style, both extremes of the digit count
		send_number('0, 5'd1, 5'd10, 1'b0, CH_NUL);
		send_number('0, 5'd20, 5'd10, 1'b0, CH_ZERO);
		send_number('0, 5'd20, 5'd10, 1'b0, CH_NUL);
		// All ones, unsigned and signed
		send_number('1, 5'd20, 5'd10, 1'b0, CH_SPACE);
		send_number('1, 5'd20, 5'd10, 1'b1, CH_SPACE);
		send_number('1, 5'd20, 5'd2, 1'b1, CH_NUL);
		// Most negative value wraps onto itself
		send_number(64'h8000_0000_0000_0000, 5'd20, 5'd10, 1'b1, CH_SPACE);
		send_number(64'h8000_0000_0000_0000, 5'd16, 5'd16, 1'b1, CH_NUL);
		// Every hex letter and digit
		send_number('1, 5'd16, 5'd16, 1'b0, CH_ZERO);
		send_number(64'hFEDC_BA98_7654_3210, 5'd16, 5'd16, 1'b0, CH_NUL);
		// Digit count zero and above the maximum
		send_number(64'd12345, 5'd0, 5'd10, 1'b0, CH_ZERO);
		send_number(64'h0123_4567_89AB_CDEF, 5'd31, 5'd10, 1'b0, CH_SPACE);
		send_number('1, 5'd21, 5'd2, 1'b0, CH_NUL);
		// Radix below two and above sixteen
		send_number(64'hA5, 5'd8, 5'd0, 1'b0, CH_ZERO);
		send_number(64'h5A, 5'd8, 5'd1, 1'b0, CH_NUL);
		send_number(64'hBEEF, 5'd6, 5'd17, 1'b0, CH_ZERO);
		// Weights past 64 bits hold zero digits, then a radix-three truncation
		send_number('1, 5'd20, 5'd31, 1'b0, CH_STAR);
		send_number('1, 5'd20, 5'd3, 1'b0, CH_SPACE);
		// Higher digits dropped, all-zero truncation with padding
		send_number(64'd1234567, 5'd3, 5'd10, 1'b0, CH_NUL);
		send_number(64'd1000, 5'd3, 5'd10, 1'b0, CH_STAR);
		// Signed mode with a positive value, odd pad bytes, octal
		send_number(64'd42, 5'd5, 5'd10, 1'b1, CH_SPACE);
		send_number(64'd5, 5'd10, 5'd10, 1'b0, 8'hFF);
		send_number(64'd5, 5'd5, 5'd8, 1'b0, CH_ZERO);

		for (n = 0; n < RANDOM_ITEMS; n++)
			send_random_number();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);

		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("integer_to_padded_ascii_unit verification clean");
		else
			$display("integer_to_padded_ascii_unit verification failed");
		$finish;
	end

	// Output side: random stalls, one long hold-off, one stretch always ready
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES)
				m_axis_tready <= 1'b0;
			else if (rx_cycle >= CALM_RX_LO && rx_cycle < CALM_RX_HI)
				m_axis_tready <= 1'b1;
			else
				m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles <= 0;
			else if (quiet_cycles + 1 >= STALL_LIMIT) begin
				$display("integer_to_padded_ascii_unit verification failed");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
